/* src/zfr_pkg.sv */
// ============================================================================
// zfr_pkg
// Shared types and constants for the frame receiver.
// ============================================================================
`timescale 1ns / 1ps

package zfr_pkg;

   localparam int GREETING_BYTES    = 64;
   localparam int LONG_LENGTH_BYTES = 8;
   localparam logic [7:0] MAX_FRAMES_RESET = 8'd16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_GREET = 3'd1,
      PH_FLAGS = 3'd3,
      PH_LEN   = 3'd4,
      PH_BODY  = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_SEND_GREETING = 4'd1,
      EV_GREET_OK      = 4'd2,
      EV_FLAGS         = 4'd3,
      EV_LENGTH        = 4'd4,
      EV_BODY          = 4'd5,
      EV_CMD_OK        = 4'd6,
      EV_NOT_IDLE      = 4'd7,
      EV_NOT_CONN      = 4'd8,
      EV_VERSION       = 4'd9,
      EV_OVERFLOW      = 4'd10,
      EV_PROTOCOL      = 4'd11
   } event_type;

   localparam int FL_MORE    = 0;
   localparam int FL_LARGE   = 1;
   localparam int FL_COMMAND = 2;

   // classified input item handed from front to back
   typedef struct packed {
      logic       is_byte;
      logic [7:0] value;
   } item_type;

   // one result
   typedef struct packed {
      logic       peer_ready;
      logic       frame_more;
      logic [7:0] frame_count;
      logic       message_done;
      logic       frame_done;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [3:0] event_res;
   } result_type;

   function automatic logic [7:0] ready_char(input logic [2:0] idx);
      case (idx)
         3'd0:    ready_char = 8'h05;
         3'd1:    ready_char = 8'h52;
         3'd2:    ready_char = 8'h45;
         3'd3:    ready_char = 8'h41;
         3'd4:    ready_char = 8'h44;
         3'd5:    ready_char = 8'h59;
         default: ready_char = 8'h00;
      endcase
   endfunction

   function automatic logic greeting_ok(input logic [5:0] idx, input logic [7:0] b);
      logic ok;
      ok = (b == 8'h00);
      if (idx == 6'd0) ok = (b == 8'hff);
      else if (idx <= 6'd8) ok = 1'b1;
      else if (idx == 6'd9) ok = (b == 8'h7f);
      else if (idx == 6'd10) ok = (b >= 8'd3);
      else if (idx == 6'd11) ok = 1'b1;
      else if (idx == 6'd12) ok = (b == 8'h4e);
      else if (idx == 6'd13) ok = (b == 8'h55);
      else if (idx == 6'd14 || idx == 6'd15) ok = (b == 8'h4c);
      return ok;
   endfunction

endpackage

/* src/zmtp_frame_receiver.sv */
// ============================================================================
// zmtp_frame_receiver
// Receive side of a NULL-mechanism link: greeting check and frame parser.
// ============================================================================
// path: an accepted req transaction is stored in the front queue, then parsed into the registered result stage
// throughput: one byte per cycle while rsp_tready drains the result stage; a stalled rsp holds the parser
// reset: synchronous, clears parser state to idle and max_frames to 16
`timescale 1ns / 1ps

module zmtp_frame_receiver #(
   parameter int QueueDepth = zfr_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,      // max_frames
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // in_byte
   input  logic        req_tuser,      // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_res[3:0], data_byte[11:4], data_valid[12], frame_done[13],
   // message_done[14], frame_count[22:15], frame_more[23], peer_ready[24]
   output logic [31:0] rsp_tdata
);
   import zfr_pkg::*;

   logic [7:0] max_frames_ff;
   item_type   req_item, q_item;
   logic       q_valid, q_ready;
   result_type res;

   // max_frames register
   always_ff @(posedge clock) begin
      if (reset) max_frames_ff <= MAX_FRAMES_RESET;
      else if (csr_we) max_frames_ff <= csr_wdata;
   end

   assign req_item.is_byte = req_tuser;
   assign req_item.value   = req_tdata;

   // front: accept and queue transactions
   zfr_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(req_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   // back: parse and register the result
   zfr_back u_back (
      .clock, .reset, .max_frames(max_frames_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {7'd0, res.peer_ready, res.frame_more, res.frame_count,
                       res.message_done, res.frame_done, res.data_valid,
                       res.data_byte, res.event_res};

endmodule

/* src/zfr_front.sv */
// ============================================================================
// zfr_front
// Accepts input transactions into a short queue for the parser.
// ============================================================================
`timescale 1ns / 1ps

module zfr_front #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  zfr_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output zfr_pkg::item_type out_item
);
   import zfr_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   item_type          mem_ff [Depth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end

endmodule

/* src/zfr_back.sv */
// ============================================================================
// zfr_back
// Greeting check and frame parser with a registered result stage.
// ============================================================================
`timescale 1ns / 1ps

module zfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          max_frames,
   input  logic                in_valid,
   output logic                in_ready,
   input  zfr_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output zfr_pkg::result_type out_res
);
   import zfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  idx_ff, idx_in;          // greeting and length byte index
   logic [63:0] acc_ff, acc_in;
   logic [63:0] size_ff, size_in;
   logic [63:0] body_ff, body_in;        // body byte count
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  seen_ff, seen_in;
   logic        match_ff, match_in;
   logic        rdy_ff, rdy_in;
   logic        ov_ff;
   result_type  res_ff, res;
   logic        take;

   assign in_ready  = !ov_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   always_comb begin
      logic       fin, fd, md, clr, ok;
      logic [63:0] fsz;
      logic [63:0] bnext;
      event_type  ev;
      phase_in = phase_ff; idx_in = idx_ff; acc_in = acc_ff; size_in = size_ff;
      body_in = body_ff; flags_in = flags_ff; seen_in = seen_ff;
      match_in = match_ff; rdy_in = rdy_ff;
      fin = 1'b0; fd = 1'b0; md = 1'b0; clr = 1'b0; ok = 1'b0;
      fsz = size_ff; bnext = body_ff + 64'd1;
      ev = EV_NONE;
      res = '0;
      if (!in_item.is_byte) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_GREET; idx_in = '0; ev = EV_SEND_GREETING;
         end else begin
            ev = EV_NOT_IDLE;
         end
      end else begin
         case (phase_ff)
            PH_GREET: begin
               if (!greeting_ok(idx_ff, in_item.value)) begin
                  clr = 1'b1; ev = EV_VERSION;
               end else begin
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'(GREETING_BYTES-1)) begin
                     idx_in = '0; phase_in = PH_FLAGS; ev = EV_GREET_OK;
                  end
               end
            end
            PH_FLAGS: begin
               if (seen_ff < max_frames) begin
                  flags_in = in_item.value; idx_in = '0; acc_in = '0;
                  match_in = 1'b1; phase_in = PH_LEN; ev = EV_FLAGS;
               end else begin
                  ev = EV_OVERFLOW;
               end
            end
            PH_LEN: begin
               ev = EV_LENGTH;
               body_in = '0;
               if (flags_ff[FL_LARGE]) begin
                  acc_in = {acc_ff[55:0], in_item.value};
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'(LONG_LENGTH_BYTES-1)) begin
                     fsz = {acc_ff[55:0], in_item.value};
                     size_in = fsz; acc_in = '0; idx_in = '0;
                     phase_in = PH_BODY;
                     fin = (fsz == '0);
                  end
               end else begin
                  fsz = {56'd0, in_item.value};
                  size_in = fsz; phase_in = PH_BODY;
                  fin = (fsz == '0);
               end
            end
            PH_BODY: begin
               ev = EV_BODY;
               if (flags_ff[FL_COMMAND]) begin
                  if (body_ff < 64'd6 && in_item.value != ready_char(body_ff[2:0]))
                     match_in = 1'b0;
               end else begin
                  res.data_byte = in_item.value; res.data_valid = 1'b1;
               end
               body_in = bnext;
               fin = (bnext >= size_ff);
               fsz = size_ff;
            end
            default: ev = EV_NOT_CONN;
         endcase
      end
      if (fin) begin
         body_in = '0; idx_in = '0; phase_in = PH_FLAGS;
         if (flags_ff[FL_COMMAND]) begin
            ok = (fsz >= 64'd6) && match_in;
            match_in = 1'b1;
            if (!ok) begin
               clr = 1'b1; ev = EV_PROTOCOL;
            end else begin
               rdy_in = 1'b1; ev = EV_CMD_OK;
            end
         end else begin
            match_in = 1'b1;
            seen_in = seen_ff + 8'd1;
            fd = 1'b1; md = !flags_ff[FL_MORE];
         end
      end
      if (clr) begin
         phase_in = PH_IDLE; idx_in = '0; acc_in = '0; size_in = '0; body_in = '0;
         flags_in = '0; seen_in = '0; match_in = 1'b1; rdy_in = 1'b0;
      end
      res.event_res    = ev;
      res.frame_done   = fd;
      res.message_done = md;
      res.frame_count  = seen_in;
      res.frame_more   = flags_in[FL_MORE];
      res.peer_ready   = rdy_in;
      if (md) seen_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; idx_ff <= '0; acc_ff <= '0; size_ff <= '0;
         body_ff <= '0; flags_ff <= '0; seen_ff <= '0; match_ff <= 1'b1;
         rdy_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; idx_ff <= idx_in; acc_ff <= acc_in;
            size_ff <= size_in; body_ff <= body_in; flags_ff <= flags_in;
            seen_ff <= seen_in; match_ff <= match_in; rdy_ff <= rdy_in;
         end
         if (take) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (take) res_ff <= res;
   end

endmodule

/* sim/tb_zmtp_frame_receiver.sv */
// ============================================================================
// tb_zmtp_frame_receiver
// Stream testbench for the frame receiver: a queue-fed driver pushes connect
// and byte transactions, a scoreboard predicts each response and a monitor
// compares every field of every rsp transaction against it.
// ============================================================================
`timescale 1ns / 1ps

module tb_zmtp_frame_receiver;
   import zfr_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;

   // input item as the driver sends it
   typedef struct packed {
      logic       mode;
      logic [7:0] value;
   } link_item;

   // expected response fields
   typedef struct packed {
      logic       peer_ready;
      logic       frame_more;
      logic [7:0] frame_count;
      logic       message_done;
      logic       frame_done;
      logic       data_valid;
      logic [7:0] data_byte;
      event_type  event_res;
   } link_result;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   zmtp_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // pending stimulus and expected responses
   link_item   pending_items[$];
   link_result expected_results[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_off_cycles = 0;
   int  error_count = 0;
   int  cycle_count = 0;

   // parser mirror
   logic [7:0]  frame_limit;
   phase_type   link_phase;
   logic [63:0] pos_count;
   logic [63:0] size_accum;
   logic [63:0] body_size;
   logic [7:0]  flag_bits;
   logic [7:0]  msg_frames;
   logic        cmd_good;
   logic        peer_is_ready;

   function automatic void clear_link_state();
      link_phase    = PH_IDLE;
      pos_count     = '0;
      size_accum    = '0;
      body_size     = '0;
      flag_bits     = '0;
      msg_frames    = '0;
      cmd_good      = 1'b1;
      peer_is_ready = 1'b0;
   endfunction

   function automatic logic greet_byte_valid(logic [63:0] idx, logic [7:0] b);
      if (idx == 0) return b == 8'hff;
      if (idx <= 8) return 1'b1;
      if (idx == 9) return b == 8'h7f;
      if (idx == 10) return b >= 8'd3;
      if (idx == 11) return 1'b1;
      if (idx == 12) return b == "N";
      if (idx == 13) return b == "U";
      if (idx == 14 || idx == 15) return b == "L";
      return b == 8'h00;
   endfunction

   function automatic logic [7:0] ready_letter(logic [63:0] idx);
      case (idx)
         0:       return 8'h05;
         1:       return "R";
         2:       return "E";
         3:       return "A";
         4:       return "D";
         default: return "Y";
      endcase
   endfunction

   // closes the current frame, updates the result in place
   function automatic void close_frame(inout link_result r);
      pos_count  = '0;
      link_phase = PH_FLAGS;
      if (flag_bits[FL_COMMAND]) begin
         logic ok;
         ok = (body_size >= 6) && cmd_good;
         cmd_good = 1'b1;
         if (!ok) begin
            clear_link_state();
            r.event_res = EV_PROTOCOL;
         end else begin
            peer_is_ready = 1'b1;
            r.event_res = EV_CMD_OK;
         end
      end else begin
         cmd_good = 1'b1;
         msg_frames = msg_frames + 8'd1;
         r.frame_done = 1'b1;
         if (!flag_bits[FL_MORE]) r.message_done = 1'b1;
      end
   endfunction

   // works out the response to one accepted transaction
   function automatic link_result parse_step(link_item it);
      link_result r;
      r = '0;
      r.event_res = EV_NONE;
      if (!it.mode) begin
         if (link_phase == PH_IDLE) begin
            link_phase  = PH_GREET;
            pos_count   = '0;
            r.event_res = EV_SEND_GREETING;
         end else begin
            r.event_res = EV_NOT_IDLE;
         end
      end else begin
         case (link_phase)
            PH_GREET: begin
               if (!greet_byte_valid(pos_count, it.value)) begin
                  clear_link_state();
                  r.event_res = EV_VERSION;
               end else begin
                  pos_count++;
                  if (pos_count >= GREETING_BYTES) begin
                     pos_count   = '0;
                     link_phase  = PH_FLAGS;
                     r.event_res = EV_GREET_OK;
                  end
               end
            end
            PH_FLAGS: begin
               if (msg_frames < frame_limit) begin
                  flag_bits   = it.value;
                  pos_count   = '0;
                  size_accum  = '0;
                  cmd_good    = 1'b1;
                  link_phase  = PH_LEN;
                  r.event_res = EV_FLAGS;
               end else begin
                  r.event_res = EV_OVERFLOW;
               end
            end
            PH_LEN: begin
               logic done;
               done = 1'b1;
               r.event_res = EV_LENGTH;
               if (flag_bits[FL_LARGE]) begin
                  size_accum = {size_accum[55:0], it.value};
                  pos_count++;
                  if (pos_count >= LONG_LENGTH_BYTES) begin
                     body_size  = size_accum;
                     size_accum = '0;
                     pos_count  = '0;
                  end else begin
                     done = 1'b0;
                  end
               end else begin
                  body_size = {56'd0, it.value};
               end
               if (done) begin
                  link_phase = PH_BODY;
                  if (body_size == 0) close_frame(r);
               end
            end
            PH_BODY: begin
               r.event_res = EV_BODY;
               if (flag_bits[FL_COMMAND]) begin
                  if (pos_count < 6 && it.value != ready_letter(pos_count)) cmd_good = 1'b0;
               end else begin
                  r.data_byte  = it.value;
                  r.data_valid = 1'b1;
               end
               pos_count++;
               if (pos_count >= body_size) close_frame(r);
            end
            default: r.event_res = EV_NOT_CONN;
         endcase
      end
      r.frame_count = msg_frames;
      if (r.message_done) msg_frames = '0;
      r.frame_more = flag_bits[FL_MORE];
      r.peer_ready = peer_is_ready;
      return r;
   endfunction

   // driver: one nonblocking write per signal per edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         logic accepted;
         link_item nxt;
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            link_item cur;
            cur = pending_items.pop_front();
            expected_results.push_back(parse_step(cur));
         end
         if ((!req_tvalid || accepted) ) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_items[0];
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.mode;
               req_tdata  <= nxt.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with random idling and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: compare each rsp transaction field by field
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         link_result got, want;
         got.event_res    = event_type'(rsp_tdata[3:0]);
         got.data_byte    = rsp_tdata[11:4];
         got.data_valid   = rsp_tdata[12];
         got.frame_done   = rsp_tdata[13];
         got.message_done = rsp_tdata[14];
         got.frame_count  = rsp_tdata[22:15];
         got.frame_more   = rsp_tdata[23];
         got.peer_ready   = rsp_tdata[24];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected rsp transaction, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.event_res !== want.event_res) begin
               $display("%0t: event_res expected %0d actual %0d", $time, want.event_res, got.event_res);
               error_count++;
            end
            if (got.data_byte !== want.data_byte) begin
               $display("%0t: data_byte expected %h actual %h", $time, want.data_byte, got.data_byte);
               error_count++;
            end
            if (got.data_valid !== want.data_valid) begin
               $display("%0t: data_valid expected %b actual %b", $time, want.data_valid, got.data_valid);
               error_count++;
            end
            if (got.frame_done !== want.frame_done) begin
               $display("%0t: frame_done expected %b actual %b", $time, want.frame_done, got.frame_done);
               error_count++;
            end
            if (got.message_done !== want.message_done) begin
               $display("%0t: message_done expected %b actual %b", $time, want.message_done,
                  got.message_done);
               error_count++;
            end
            if (got.frame_count !== want.frame_count) begin
               $display("%0t: frame_count expected %0d actual %0d", $time, want.frame_count,
                  got.frame_count);
               error_count++;
            end
            if (got.frame_more !== want.frame_more) begin
               $display("%0t: frame_more expected %b actual %b", $time, want.frame_more, got.frame_more);
               error_count++;
            end
            if (got.peer_ready !== want.peer_ready) begin
               $display("%0t: peer_ready expected %b actual %b", $time, want.peer_ready, got.peer_ready);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus builders
   task automatic push_item(logic mode, logic [7:0] value);
      link_item it;
      it.mode  = mode;
      it.value = value;
      pending_items.push_back(it);
   endtask

   task automatic push_greeting(logic [7:0] major, logic [7:0] pad);
      for (int i = 0; i < GREETING_BYTES; i++) begin
         logic [7:0] b;
         b = 8'h00;
         if (i == 0) b = 8'hff;
         else if (i <= 8) b = pad ^ 8'(i);
         else if (i == 9) b = 8'h7f;
         else if (i == 10) b = major;
         else if (i == 11) b = pad;
         else if (i == 12) b = "N";
         else if (i == 13) b = "U";
         else if (i == 14 || i == 15) b = "L";
         push_item(1'b1, b);
      end
   endtask

   task automatic push_connect_greet();
      push_item(1'b0, 8'($urandom));
      push_greeting(8'($urandom_range(3, 255)), 8'($urandom));
   endtask

   // frame with a small body; large selects the eight-byte length form
   task automatic push_frame(logic [7:0] flags, int body_len, logic is_ready);
      push_item(1'b1, flags);
      if (flags[FL_LARGE]) begin
         for (int i = 7; i >= 0; i--) push_item(1'b1, 8'(body_len >> (8 * i)));
      end else begin
         push_item(1'b1, 8'(body_len));
      end
      for (int i = 0; i < body_len; i++) begin
         if (is_ready && i < 6) push_item(1'b1, ready_letter(64'(i)));
         else push_item(1'b1, 8'($urandom));
      end
   endtask

   task automatic push_message(int nframes);
      for (int f = 0; f < nframes; f++) begin
         logic [7:0] fl;
         fl = 8'($urandom) & ~(8'd1 << FL_COMMAND);
         fl[FL_MORE] = (f != nframes - 1);
         push_frame(fl, $urandom_range(0, 6), 1'b0);
      end
   endtask

   // random link session: mostly well formed, some noise
   task automatic push_session();
      int pick;
      push_connect_greet();
      push_frame(8'($urandom) | 8'h04, $urandom_range(6, 9), 1'b1);
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(99);
         if (pick < 70) push_message($urandom_range(1, 5));
         else if (pick < 80) push_item(1'b0, 8'($urandom));
         else if (pick < 90) push_frame(8'h04, $urandom_range(0, 7), 1'($urandom_range(1)));
         else push_item(1'b1, 8'($urandom));
      end
      // connect with a broken greeting between sessions
      if ($urandom_range(3) == 0) begin
         push_item(1'b0, 8'h00);
         push_greeting(8'($urandom_range(0, 2)), 8'h00);
      end
   endtask

   // run the queue dry and let the pipeline settle
   task automatic drain();
      while (pending_items.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      frame_limit = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      rsp_tready = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      frame_limit = MAX_FRAMES_RESET;
      clear_link_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte while idle, connect, bad signature, reconnect
      push_item(1'b1, 8'hff);
      push_item(1'b0, 8'h00);
      push_item(1'b1, 8'h00);
      push_item(1'b0, 8'hff);
      push_greeting(8'd3, 8'hff);
      push_item(1'b0, 8'h00);
      // short ready command gives a protocol error
      push_frame(8'h04, 3, 1'b1);
      drain();

      // directed at limit 1: large-length command, empty frame, then overflow on the next frame
      write_limit(8'd1);
      push_connect_greet();
      push_frame(8'h07, 6, 1'b1);
      push_frame(8'h03, 0, 1'b0);
      push_item(1'b1, 8'hf8);
      push_frame(8'hfa, 2, 1'b0);
      push_greeting(8'd2, 8'h00);
      drain();

      // phase one: sender idles 27, receiver 63, limit at the top
      write_limit(8'd255);
      send_idle_pct = 27;
      recv_idle_pct = 63;
      while (pending_items.size() < 280) push_session();
      drain();

      // phase two: swapped, small limit, one long hold-off
      write_limit(8'd2);
      send_idle_pct = 63;
      recv_idle_pct = 27;
      while (pending_items.size() < 280) push_session();
      hold_off_cycles = 300;
      drain();

      // phase three: no idling, mid limit
      write_limit(8'($urandom_range(3, 8)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending_items.size() < 280) push_session();
      drain();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
